[rtl/core/assert_macros.svh]
// assertion macros shared by the rtl/core files
// no dependencies; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)

`endif

`endif

[rtl/core/swef_pkg.sv]
// shared types, widths and register codes for the select-with-falloff block
// no dependencies
`timescale 1ns / 1ps

package swef_pkg;

    // sample format: signed fixed point with FRAC_BITS fraction bits
    localparam int SAMPLE_W  = 18;
    localparam int FRAC_BITS = 14;
    localparam int ONE_FX    = 1 << FRAC_BITS;

    // derived widths of the blend path
    localparam int THR_W = FRAC_BITS + 3;
    localparam int DEN_W = FRAC_BITS + 1;
    localparam int REM_W = FRAC_BITS + 2;

    // divider pipeline shape
    localparam int DIV_STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES          = FRAC_BITS / DIV_STEPS_PER_STAGE;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FALLOFF = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [THR_W-1:0]    t_thr;
    typedef logic [FRAC_BITS-1:0]       t_frac;
    typedef logic [DEN_W-1:0]           t_den;
    typedef logic [REM_W-1:0]           t_rem;

    // register reset values
    localparam t_sample RST_LOWER   = t_sample'(4915);
    localparam t_sample RST_UPPER   = t_sample'(16384);
    localparam t_sample RST_FALLOFF = t_sample'(4096);

    // blend endpoints: result = x + (y - x) * s
    typedef struct packed {
        t_sample x;
        t_sample y;
    } t_pair;

    // band settings worked out from the registers
    typedef struct packed {
        t_sample lo;
        t_sample hi;
        logic    hard;
        t_thr    lo_me;
        t_thr    lo_pe;
        t_thr    hi_me;
        t_thr    hi_pe;
        t_den    den;
    } t_cfg;

endpackage

[rtl/core/select_with_edge_falloff_unit.sv]
// Select with edge falloff: each item carries a control sample and two source samples
// (signed Q3.14) and gives one selected sample. Outside the band the result is source A,
// inside it source B, and within the falloff distance of either edge the two are blended
// with the s-curve 3t^2 - 2t^3. One item is accepted per cycle while o_ready is high.
// Items pass through the input and classify stages, the seven-stage divider that finds
// the blend position (two quotient bits per stage) and the five multiply/round stages
// of the blend. A two-entry result queue sits at the output; input ready drops only while
// that queue is full and the last pipeline stage holds an item. A configuration write
// applies to items accepted from the next cycle on, and to a stalled input-stage item.
// Depends on swef_pkg, swef_cfg, swef_div, swef_blend, swef_ofifo and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module select_with_edge_falloff_unit
    import swef_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // configuration
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_sample              i_cfg_wdata,
    // input items
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_sample              i_control_value,
    input  t_sample              i_source_a,
    input  t_sample              i_source_b,
    // result items
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_sample              o_selected_value
);

    t_cfg    w_cfg;
    logic    w_en;
    logic    w_full;
    logic    w_div_vld;
    t_frac   w_div_quo;
    t_pair   w_div_pair;
    logic    w_blend_vld;
    t_sample w_blend_value;

    logic    r_s1_vld;
    t_sample r_s1_c;
    t_sample r_s1_a;
    t_sample r_s1_b;

    logic    r_s2_vld;
    t_frac   r_s2_num;
    t_den    r_s2_den;
    t_pair   r_s2_pair;

    t_frac                    n_s2_num;
    t_pair                    n_s2_pair;
    logic signed [SAMPLE_W:0] w_off_lo;
    logic signed [SAMPLE_W:0] w_off_hi;

    // configuration registers
    swef_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    // pipeline advances unless the last stage is blocked by a full queue
    assign w_en    = !w_blend_vld || !w_full;
    assign o_ready = w_en;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (w_en) begin
            r_s1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_c <= i_control_value;
            r_s1_a <= i_source_a;
            r_s1_b <= i_source_b;
        end
    end

    // classify the control sample against the band and its falloff zones
    always_comb begin
        w_off_lo  = (SAMPLE_W+1)'(r_s1_c) - (SAMPLE_W+1)'($signed(w_cfg.lo_me));
        w_off_hi  = (SAMPLE_W+1)'(r_s1_c) - (SAMPLE_W+1)'($signed(w_cfg.hi_me));
        n_s2_num  = '0;
        n_s2_pair = '{x: r_s1_a, y: r_s1_a};
        if (w_cfg.hard) begin
            if (r_s1_c < $signed(w_cfg.lo) || r_s1_c > $signed(w_cfg.hi)) begin
                n_s2_pair = '{x: r_s1_a, y: r_s1_a};
            end else begin
                n_s2_pair = '{x: r_s1_b, y: r_s1_b};
            end
        end else if (r_s1_c < $signed(w_cfg.lo_me)) begin
            n_s2_pair = '{x: r_s1_a, y: r_s1_a};
        end else if (r_s1_c < $signed(w_cfg.lo_pe)) begin
            n_s2_pair = '{x: r_s1_a, y: r_s1_b};
            n_s2_num  = w_off_lo[FRAC_BITS-1:0];
        end else if (r_s1_c < $signed(w_cfg.hi_me)) begin
            n_s2_pair = '{x: r_s1_b, y: r_s1_b};
        end else if (r_s1_c < $signed(w_cfg.hi_pe)) begin
            n_s2_pair = '{x: r_s1_b, y: r_s1_a};
            n_s2_num  = w_off_hi[FRAC_BITS-1:0];
        end else begin
            n_s2_pair = '{x: r_s1_a, y: r_s1_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (w_en) begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2_num  <= n_s2_num;
            r_s2_den  <= w_cfg.den;
            r_s2_pair <= n_s2_pair;
        end
    end

    // blend position
    swef_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_s2_vld),
        .i_num   (r_s2_num),
        .i_den   (r_s2_den),
        .i_pair  (r_s2_pair),
        .o_vld   (w_div_vld),
        .o_quo   (w_div_quo),
        .o_pair  (w_div_pair)
    );

    // s-curve weight and blend
    swef_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (w_div_vld),
        .i_t     (w_div_quo),
        .i_pair  (w_div_pair),
        .o_vld   (w_blend_vld),
        .o_value (w_blend_value)
    );

    // result queue
    swef_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_blend_vld && w_en),
        .i_data  (w_blend_value),
        .o_full  (w_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_selected_value)
    );

    // a soft edge always has a nonzero divisor
    `ASSERT_IMPLY(a_soft_den_nonzero, i_clk, i_rst_n, !w_cfg.hard, w_cfg.den != '0)

    // falloff zones are ordered along the control axis
    `ASSERT_IMPLY(a_zone_order, i_clk, i_rst_n, !w_cfg.hard,
        ($signed(w_cfg.lo_me) < $signed(w_cfg.lo_pe)) &&
        ($signed(w_cfg.lo_pe) <= $signed(w_cfg.hi_me)) &&
        ($signed(w_cfg.hi_me) < $signed(w_cfg.hi_pe)))

    // a real blend enters the divider with a position below one
    `ASSERT_IMPLY(a_num_below_den, i_clk, i_rst_n,
        r_s2_vld && (r_s2_pair.x != r_s2_pair.y), r_s2_num < r_s2_den)

endmodule

[rtl/core/swef_cfg.sv]
// configuration registers and the band settings derived from them
// depends on swef_pkg
`timescale 1ns / 1ps

module swef_cfg
    import swef_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  t_sample              i_cfg_wdata,
    output t_cfg                 o_cfg
);

    // derived settings for the reset register values
    localparam t_cfg CFG_RESET = '{
        lo:    t_sample'(4915),
        hi:    t_sample'(16384),
        hard:  1'b0,
        lo_me: t_thr'(819),
        lo_pe: t_thr'(9011),
        hi_me: t_thr'(12288),
        hi_pe: t_thr'(20480),
        den:   t_den'(8192)
    };

    t_sample r_lower;
    t_sample r_upper;
    t_sample r_falloff;
    t_cfg    r_cfg;
    t_cfg    n_cfg;

    t_sample                   w_lo_s;
    t_sample                   w_hi_s;
    t_sample                   w_lo_c;
    t_sample                   w_hi_c;
    t_sample                   w_eff;
    logic signed [SAMPLE_W:0]  w_size;
    logic signed [SAMPLE_W:0]  w_e2;
    logic signed [SAMPLE_W:0]  w_e2_eff;
    logic signed [SAMPLE_W:0]  w_lo_me;
    logic signed [SAMPLE_W:0]  w_lo_pe;
    logic signed [SAMPLE_W:0]  w_hi_me;
    logic signed [SAMPLE_W:0]  w_hi_pe;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower   <= RST_LOWER;
            r_upper   <= RST_UPPER;
            r_falloff <= RST_FALLOFF;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LOWER:   r_lower   <= i_cfg_wdata;
                CFG_UPPER:   r_upper   <= i_cfg_wdata;
                CFG_FALLOFF: r_falloff <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // order and clamp the bounds, limit the falloff to half the band
    always_comb begin
        w_lo_s = (r_lower > r_upper) ? r_upper : r_lower;
        w_hi_s = (r_lower > r_upper) ? r_lower : r_upper;
        w_hi_c = (w_hi_s > t_sample'(ONE_FX)) ? t_sample'(ONE_FX) : w_hi_s;
        w_lo_c = (w_lo_s < 0) ? t_sample'(0) : w_lo_s;
        w_size = (SAMPLE_W+1)'(w_hi_c) - (SAMPLE_W+1)'(w_lo_c);
        w_e2   = (SAMPLE_W+1)'(r_falloff) <<< 1;
        if (w_e2 > w_size) begin
            w_eff = (w_size >= 0) ? t_sample'(w_size >>> 1) : t_sample'(-1);
        end else begin
            w_eff = r_falloff;
        end
        w_e2_eff = (SAMPLE_W+1)'(w_eff) <<< 1;
        w_lo_me  = (SAMPLE_W+1)'(w_lo_c) - (SAMPLE_W+1)'(w_eff);
        w_lo_pe  = (SAMPLE_W+1)'(w_lo_c) + (SAMPLE_W+1)'(w_eff);
        w_hi_me  = (SAMPLE_W+1)'(w_hi_c) - (SAMPLE_W+1)'(w_eff);
        w_hi_pe  = (SAMPLE_W+1)'(w_hi_c) + (SAMPLE_W+1)'(w_eff);

        n_cfg.lo    = w_lo_c;
        n_cfg.hi    = w_hi_c;
        n_cfg.hard  = (w_eff <= 0);
        n_cfg.lo_me = w_lo_me[THR_W-1:0];
        n_cfg.lo_pe = w_lo_pe[THR_W-1:0];
        n_cfg.hi_me = w_hi_me[THR_W-1:0];
        n_cfg.hi_pe = w_hi_pe[THR_W-1:0];
        n_cfg.den   = w_e2_eff[DEN_W-1:0];
    end

    // settings follow the registers in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/swef_div.sv]
// pipelined restoring divider for the blend position t = (n << FRAC_BITS) / den
// depends on swef_pkg; two quotient bits per stage
`timescale 1ns / 1ps

module swef_div
    import swef_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_frac i_num,
    input  t_den  i_den,
    input  t_pair i_pair,
    output logic  o_vld,
    output t_frac o_quo,
    output t_pair o_pair
);

    typedef struct packed {
        t_rem  rem;
        t_frac quo;
        t_den  den;
        t_pair pair;
    } t_div_lane;

    // a few shift-compare-subtract steps of the division
    function automatic t_div_lane div_step(t_div_lane lane);
        t_div_lane nxt;
        t_rem      sh;
        nxt = lane;
        for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
            sh = {nxt.rem[REM_W-2:0], 1'b0};
            if (sh >= t_rem'(nxt.den)) begin
                nxt.rem = sh - t_rem'(nxt.den);
                nxt.quo = {nxt.quo[FRAC_BITS-2:0], 1'b1};
            end else begin
                nxt.rem = sh;
                nxt.quo = {nxt.quo[FRAC_BITS-2:0], 1'b0};
            end
        end
        return nxt;
    endfunction

    logic [DIV_STAGES-1:0] r_vld;
    t_div_lane             w_lane_in [DIV_STAGES];
    t_div_lane             n_lane    [DIV_STAGES];
    t_div_lane             r_lane    [DIV_STAGES];

    // stage inputs: the item for the first, the previous stage for the rest
    assign w_lane_in[0] = '{rem: t_rem'(i_num), quo: '0, den: i_den, pair: i_pair};
    for (genvar g = 1; g < DIV_STAGES; g++) begin : g_link
        assign w_lane_in[g] = r_lane[g-1];
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_step
        assign n_lane[g] = div_step(w_lane_in[g]);
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[DIV_STAGES-2:0], i_vld};
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_vld  = r_vld[DIV_STAGES-1];
    assign o_quo  = r_lane[DIV_STAGES-1].quo;
    assign o_pair = r_lane[DIV_STAGES-1].pair;

endmodule

[rtl/core/swef_blend.sv]
// s-curve weight 3t^2 - 2t^3 and the rounded, saturated blend of two samples
// depends on swef_pkg; five register stages
`timescale 1ns / 1ps

module swef_blend
    import swef_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_en,
    input  logic    i_vld,
    input  t_frac   i_t,
    input  t_pair   i_pair,
    output logic    o_vld,
    output t_sample o_value
);

    localparam int STAGES = 5;
    localparam int TSQ_W  = 2 * FRAC_BITS;
    localparam int K_W    = FRAC_BITS + 2;
    localparam int P_W    = TSQ_W + K_W;
    localparam int S_W    = FRAC_BITS + 1;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PROD_W = DIFF_W + S_W + 1;

    localparam logic [P_W-1:0]           P_HALF    = P_W'(1) << (2 * FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] SAT_HI    = PROD_W'((1 << (SAMPLE_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO    = -(PROD_W'(1) <<< (SAMPLE_W - 1));

    logic [STAGES-1:0] r_vld;

    logic [TSQ_W-1:0]           r_tsq;
    logic [K_W-1:0]             r_k;
    logic signed [DIFF_W-1:0]   r1_diff;
    t_sample                    r1_x;
    logic [P_W-1:0]             r_p;
    logic signed [DIFF_W-1:0]   r2_diff;
    t_sample                    r2_x;
    logic [S_W-1:0]             r_s;
    logic signed [DIFF_W-1:0]   r3_diff;
    t_sample                    r3_x;
    logic signed [PROD_W-1:0]   r_prod;
    t_sample                    r4_x;
    t_sample                    r_out;

    logic [P_W-1:0]             w_p_rnd;
    logic signed [PROD_W-1:0]   w_prod_rnd;
    logic signed [PROD_W-1:0]   w_shift;
    logic signed [PROD_W-1:0]   w_x_ext;
    logic signed [PROD_W-1:0]   w_sum;
    t_sample                    n_out;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[STAGES-2:0], i_vld};
        end
    end

    // weight rounding and final add with saturation
    always_comb begin
        w_p_rnd    = r_p + P_HALF;
        w_prod_rnd = r_prod + PROD_HALF;
        w_shift    = w_prod_rnd >>> FRAC_BITS;
        w_x_ext    = PROD_W'(r4_x);
        w_sum      = w_shift + w_x_ext;
        if (w_sum > SAT_HI) begin
            n_out = t_sample'(SAT_HI[SAMPLE_W-1:0]);
        end else if (w_sum < SAT_LO) begin
            n_out = t_sample'(SAT_LO[SAMPLE_W-1:0]);
        end else begin
            n_out = w_sum[SAMPLE_W-1:0];
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // t squared, 3 - 2t and the sample difference
            r_tsq   <= TSQ_W'(i_t) * TSQ_W'(i_t);
            r_k     <= K_W'(3 * ONE_FX) - {1'b0, i_t, 1'b0};
            r1_diff <= DIFF_W'(i_pair.y) - DIFF_W'(i_pair.x);
            r1_x    <= i_pair.x;
            // cubic numerator
            r_p     <= P_W'(r_tsq) * P_W'(r_k);
            r2_diff <= r1_diff;
            r2_x    <= r1_x;
            // weight rounded half up
            r_s     <= w_p_rnd[2*FRAC_BITS +: S_W];
            r3_diff <= r2_diff;
            r3_x    <= r2_x;
            // weighted difference
            r_prod  <= PROD_W'(r3_diff) * $signed({1'b0, r_s});
            r4_x    <= r3_x;
            // result
            r_out   <= n_out;
        end
    end

    assign o_vld   = r_vld[STAGES-1];
    assign o_value = r_out;

endmodule

[rtl/core/swef_ofifo.sv]
// two-entry result queue between the pipeline and the output channel
// depends on swef_pkg
`timescale 1ns / 1ps

module swef_ofifo
    import swef_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_sample i_data,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_ready,
    output t_sample o_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_sample            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wp;
    logic [PTR_W-1:0]   r_rp;
    logic [CNT_W-1:0]   r_cnt;
    logic               w_pop;

    assign w_pop = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CNT_W'(i_push) - CNT_W'(w_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];

endmodule

[tb/select_with_edge_falloff_unit_tb.sv]
// self-checking testbench for select_with_edge_falloff_unit: directed band cases,
// random band settings and items under four idling mixes, and a long output stall
// depends on swef_pkg and the select_with_edge_falloff_unit rtl
`timescale 1ns / 1ps

module select_with_edge_falloff_unit_tb;
    import swef_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
    localparam longint SAMPLE_MAX  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
    localparam longint SAMPLE_MIN  = -SAMPLE_MAX - 1;
    localparam int     QUIET_LIMIT = 2000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_sample              i_cfg_wdata;
    logic                 i_valid;
    logic                 o_ready;
    t_sample              i_control_value;
    t_sample              i_source_a;
    t_sample              i_source_b;
    logic                 o_valid;
    logic                 i_ready;
    t_sample              o_selected_value;

    // local copy of the band registers
    t_sample cfg_lower;
    t_sample cfg_upper;
    t_sample cfg_falloff;

    t_sample expected_selected[$];
    int      error_count      = 0;
    int      items_accepted   = 0;
    int      results_checked  = 0;
    int      settings_applied = 0;
    int      quiet_cycles     = 0;
    int      send_idle_pct    = 0;
    int      recv_stall_pct   = 0;
    int      hold_cycles      = 0;

    select_with_edge_falloff_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_wdata      (i_cfg_wdata),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_control_value  (i_control_value),
        .i_source_a       (i_source_a),
        .i_source_b       (i_source_b),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_selected_value (o_selected_value)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // floor((v + half lsb) / 2^n): round half toward +infinity
    function automatic longint round_shift(longint v, int n);
        return (v + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    // s-curve blend from x_val toward y_val at offset offs into a 2*half wide edge
    function automatic longint blend_edge(longint x_val, longint y_val, longint offs,
                                          longint half);
        longint pos;
        longint curve;
        pos   = (offs <<< FRAC_BITS) / (2 * half);
        curve = round_shift(pos * pos * (3 * ONE_FX - 2 * pos), 2 * FRAC_BITS);
        return x_val + round_shift((y_val - x_val) * curve, FRAC_BITS);
    endfunction

    // expected selected sample for one item under the current band registers
    function automatic t_sample calc_selected(t_sample ctl, t_sample src_a, t_sample src_b);
        longint lo;
        longint hi;
        longint fall;
        longint band;
        longint swap_tmp;
        longint res;
        lo   = cfg_lower;
        hi   = cfg_upper;
        fall = cfg_falloff;
        if (lo > hi) begin
            swap_tmp = lo;
            lo       = hi;
            hi       = swap_tmp;
        end
        if (hi > ONE_FX) hi = ONE_FX;
        if (lo < 0) lo = 0;
        // falloff limited to half the band; empty band forces hard select
        band = hi - lo;
        if (2 * fall > band) fall = (band >= 0) ? (band >>> 1) : -1;
        if (fall <= 0) begin
            if (ctl < lo || ctl > hi) res = src_a;
            else res = src_b;
        end else if (ctl < lo - fall) begin
            res = src_a;
        end else if (ctl < lo + fall) begin
            res = blend_edge(src_a, src_b, ctl - lo + fall, fall);
        end else if (ctl < hi - fall) begin
            res = src_b;
        end else if (ctl < hi + fall) begin
            res = blend_edge(src_b, src_a, ctl - hi + fall, fall);
        end else begin
            res = src_a;
        end
        if (res > SAMPLE_MAX) res = SAMPLE_MAX;
        if (res < SAMPLE_MIN) res = SAMPLE_MIN;
        return t_sample'(res);
    endfunction

    // accepted items, result checks and register writes, all seen at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_lower   = RST_LOWER;
            cfg_upper   = RST_UPPER;
            cfg_falloff = RST_FALLOFF;
        end else begin
            if (i_valid && o_ready) begin
                expected_selected.push_back(
                    calc_selected(i_control_value, i_source_a, i_source_b));
                items_accepted++;
            end
            if (o_valid && i_ready) begin
                if (expected_selected.size() == 0) begin
                    $error("selected_value with no item pending: actual %0d",
                           o_selected_value);
                    error_count++;
                end else begin
                    if (o_selected_value !== expected_selected[0]) begin
                        $error("selected_value mismatch: expected %0d, actual %0d",
                               expected_selected[0], o_selected_value);
                        error_count++;
                    end
                    void'(expected_selected.pop_front());
                    results_checked++;
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LOWER:   cfg_lower   = i_cfg_wdata;
                    CFG_UPPER:   cfg_upper   = i_cfg_wdata;
                    CFG_FALLOFF: cfg_falloff = i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // watchdog on cycles with no handshake and no register write
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready) || i_cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: %0d quiet cycles, %0d results outstanding",
                     quiet_cycles, expected_selected.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stalls plus an optional long hold-off
    initial begin
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
            end
        end
    end

    // offer one item, with random idle cycles ahead of it; returns at a falling edge
    task automatic send_item(input t_sample ctl, input t_sample src_a, input t_sample src_b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_control_value <= ctl;
        i_source_a      <= src_a;
        i_source_b      <= src_b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_selected.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // write all band registers while idle, plus a junk write to the spare index
    task automatic set_band(input t_sample lower, input t_sample upper, input t_sample falloff);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_LOWER;
        i_cfg_wdata <= lower;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_UPPER;
        i_cfg_wdata <= upper;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_FALLOFF;
        i_cfg_wdata <= falloff;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_SPARE;
        i_cfg_wdata <= t_sample'($urandom);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        @(negedge i_clk);
        settings_applied++;
    endtask

    function automatic t_sample pick_bound();
        case ($urandom_range(0, 9))
            0:       return t_sample'($urandom);
            1:       return t_sample'(int'($urandom_range(0, 4000)) - 2000);
            default: return t_sample'(int'($urandom_range(0, ONE_FX + 2000)) - 1000);
        endcase
    endfunction

    function automatic t_sample pick_falloff();
        case ($urandom_range(0, 9))
            0:       return t_sample'($urandom);
            1:       return t_sample'(0);
            2:       return t_sample'(-int'($urandom_range(1, 5000)));
            3:       return t_sample'(SAMPLE_MAX);
            default: return t_sample'($urandom_range(1, 6000));
        endcase
    endfunction

    // control mostly near one of the clamped band edges, sometimes anywhere
    function automatic t_sample pick_control();
        longint lo_edge;
        longint hi_edge;
        longint edge_pt;
        longint reach;
        lo_edge = (cfg_lower < cfg_upper) ? cfg_lower : cfg_upper;
        hi_edge = (cfg_lower < cfg_upper) ? cfg_upper : cfg_lower;
        if (lo_edge < 0) lo_edge = 0;
        if (hi_edge > ONE_FX) hi_edge = ONE_FX;
        if (cfg_falloff > 0) reach = ((cfg_falloff > 9000) ? 9000 : cfg_falloff) + 16;
        else reach = 64;
        if ($urandom_range(0, 3) == 0) return t_sample'($urandom);
        edge_pt = $urandom_range(0, 1) ? lo_edge : hi_edge;
        return t_sample'(edge_pt + longint'($urandom_range(0, 2 * reach)) - reach);
    endfunction

    function automatic t_sample pick_source();
        if ($urandom_range(0, 9) < 7) return t_sample'($urandom);
        return t_sample'(int'($urandom_range(0, 2 * ONE_FX)) - ONE_FX);
    endfunction

    // reset band 0.3..1.0 with falloff 0.25: every region and its boundaries
    task automatic test_default_band();
        send_item(t_sample'(-131072), t_sample'(131071), t_sample'(-131072));
        send_item(t_sample'(818),     t_sample'(131071), t_sample'(-131072));
        send_item(t_sample'(819),     t_sample'(131071), t_sample'(-131072));
        send_item(t_sample'(4915),    t_sample'(16384),  t_sample'(0));
        send_item(t_sample'(9010),    t_sample'(-131072), t_sample'(131071));
        send_item(t_sample'(9011),    t_sample'(-131072), t_sample'(131071));
        send_item(t_sample'(12288),   t_sample'(1000),   t_sample'(2000));
        send_item(t_sample'(16384),   t_sample'(1000),   t_sample'(-3000));
        send_item(t_sample'(20479),   t_sample'(0),      t_sample'(131071));
        send_item(t_sample'(20480),   t_sample'(0),      t_sample'(131071));
        send_item(t_sample'(131071),  t_sample'(-5),     t_sample'(7));
    endtask

    // zero and most-negative falloff, bounds at the register extremes
    task automatic test_hard_select();
        set_band(t_sample'(0), t_sample'(ONE_FX), t_sample'(0));
        send_item(t_sample'(-1),     t_sample'(1000), t_sample'(-1000));
        send_item(t_sample'(0),      t_sample'(1000), t_sample'(-1000));
        send_item(t_sample'(ONE_FX), t_sample'(1000), t_sample'(-1000));
        send_item(t_sample'(16385),  t_sample'(1000), t_sample'(-1000));
        set_band(t_sample'(-131072), t_sample'(131071), t_sample'(-131072));
        send_item(t_sample'(0),      t_sample'(-77), t_sample'(77));
        send_item(t_sample'(131071), t_sample'(-77), t_sample'(77));
    endtask

    // swapped bounds with odd width, a one-wide band and an empty band
    task automatic test_band_corners();
        set_band(t_sample'(16000), t_sample'(3001), t_sample'(131071));
        send_item(t_sample'(-3499), t_sample'(300),  t_sample'(-9000));
        send_item(t_sample'(3001),  t_sample'(5000), t_sample'(-5000));
        send_item(t_sample'(22498), t_sample'(-40),  t_sample'(9000));
        set_band(t_sample'(100), t_sample'(101), t_sample'(50));
        send_item(t_sample'(101), t_sample'(11), t_sample'(22));
        send_item(t_sample'(102), t_sample'(11), t_sample'(22));
        set_band(t_sample'(-200), t_sample'(-100), t_sample'(10));
        send_item(t_sample'(-150), t_sample'(11), t_sample'(22));
        send_item(t_sample'(0),    t_sample'(11), t_sample'(22));
    endtask

    // long output hold-off while items keep coming, so the input must stall
    task automatic test_backpressure();
        int n;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_band(t_sample'(2000), t_sample'(14000), t_sample'(3000));
        hold_cycles = 80;
        for (n = 0; n < 48; n++) send_item(pick_control(), pick_source(), pick_source());
    endtask

    // random band settings under each idling mix
    task automatic test_random_settings();
        int mix;
        int setting;
        int n;
        for (mix = 0; mix < 4; mix++) begin
            case (mix)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            for (setting = 0; setting < 4; setting++) begin
                set_band(pick_bound(), pick_bound(), pick_falloff());
                for (n = 0; n < 80; n++) send_item(pick_control(), pick_source(), pick_source());
            end
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = CFG_LOWER;
        i_cfg_wdata     = '0;
        i_valid         = 1'b0;
        i_control_value = '0;
        i_source_a      = '0;
        i_source_b      = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_default_band();
        test_hard_select();
        test_band_corners();
        test_backpressure();
        test_random_settings();

        drain_results();
        repeat (20) @(negedge i_clk);
        $display("covered %0d items and %0d checked results over %0d band settings,",
                 items_accepted, results_checked, settings_applied);
        $display("with hard, swapped, clamped and empty bands, a long stall and four idle mixes");
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
